// ===== sv/lj39wc_pkg.sv =====
// Package with shared types, constants and arithmetic helpers for the 3-9 wall contact block.
package lj39wc_pkg;

    localparam int DIST_FRAC_BITS_DEF = 28;
    localparam int NUM_W = 384;
    localparam int CAP_BITS = 60;
    localparam int NDIV = CAP_BITS + 1;
    localparam int PREP_STAGES = 10;

    typedef enum logic [2:0] {
        REG_CUTOFF  = 3'd0,
        REG_REP_E   = 3'd1,
        REG_ATT_E   = 3'd2,
        REG_REP_F   = 3'd3,
        REG_ATT_F   = 3'd4,
        REG_E_SHIFT = 3'd5,
        REG_F_SHIFT = 3'd6
    } reg_idx_t;

    typedef logic [2:0][9:0][63:0] pp_t;

    typedef struct packed {
        logic [NUM_W-1:0] mag;
        logic             neg;
    } num_t;

    typedef struct packed {
        logic               ctc;
        logic               rz;
        logic [31:0]        rdist;
        logic signed [61:0] lin;
    } side_t;

    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic pp_t mul_pp(input logic [319:0] a, input logic [95:0] b);
        pp_t p;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 10; i++) begin
                p[j][i] = {32'b0, a[32*i +: 32]} * {32'b0, b[32*j +: 32]};
            end
        end
        return p;
    endfunction

    function automatic logic [415:0] mul_sum(input pp_t p);
        logic [415:0] acc;
        logic [415:0] ev;
        logic [415:0] od;
        acc = '0;
        for (int j = 0; j < 3; j++) begin
            ev = '0;
            od = '0;
            for (int i = 0; i < 10; i++) begin
                if ((i % 2) == 0) begin
                    ev[32*i +: 64] = p[j][i];
                end else begin
                    od[32*i +: 64] = p[j][i];
                end
            end
            acc = acc + (ev << (32*j)) + (od << (32*j));
        end
        return acc;
    endfunction

    function automatic num_t comb_num(input logic [NUM_W-1:0] p, input logic [NUM_W-1:0] q,
                                      input logic pneg, input logic qneg);
        num_t n;
        if (pneg == qneg) begin
            n.mag = p + q;
            n.neg = pneg;
        end else if (p >= q) begin
            n.mag = p - q;
            n.neg = pneg;
        end else begin
            n.mag = q - p;
            n.neg = qneg;
        end
        return n;
    endfunction

    function automatic logic signed [61:0] zero_term(input logic signed [47:0] ca,
                                                     input logic signed [47:0] cb);
        logic signed [61:0] cap;
        cap = 62'sd1 <<< CAP_BITS;
        if (ca != '0) begin
            return ca[47] ? -cap : cap;
        end else if (cb != '0) begin
            return cb[47] ? cap : -cap;
        end
        return '0;
    endfunction

endpackage

// ===== sv/lj_3_9_wall_contact_force.sv =====
// Shifted-force 3-9 wall potential and force pipeline with a stream interface.

// Each beat on the input carries one distance and yields exactly one result beat. The block is
// a fixed pipeline of 72 stages: ten stages build the powers of r and the numerators with
// 32 by 32 bit partial products, 61 restoring division stages give one quotient bit each for
// potential and force in parallel, and one stage adds the shift terms and saturates. A new
// beat is taken every cycle while the output is not stalled.
// Configuration registers must only be written while the pipeline is empty.
module lj_3_9_wall_contact_force #(
    parameter int DIST_FRAC_BITS = lj39wc_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // distance[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // potential[47:0], force_res[95:48]
    output logic        m_tuser,   // in_contact
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_data
);
    import lj39wc_pkg::*;

    localparam int LAT = PREP_STAGES + NDIV + 1;
    localparam int SH_PE = 9 * DIST_FRAC_BITS;
    localparam int SH_QE = 3 * DIST_FRAC_BITS;
    localparam int SH_PF = 10 * DIST_FRAC_BITS;
    localparam int SH_QF = 4 * DIST_FRAC_BITS;

    logic [31:0]        cutoff_reg;
    logic signed [47:0] rep_e_reg;
    logic signed [47:0] att_e_reg;
    logic signed [47:0] rep_f_reg;
    logic signed [47:0] att_f_reg;
    logic signed [47:0] e_shift_reg;
    logic signed [47:0] f_shift_reg;

    logic               adv;
    logic [LAT:1]       vld_reg;
    side_t              sd_reg [1:LAT-1];

    logic               lneg_reg;
    pp_t                pp1_reg;
    pp_t                ppl_reg;
    logic [63:0]        sq_reg;
    pp_t                pp3_reg;
    logic [95:0]        cube_reg;
    logic [95:0]        cube5_reg;
    pp_t                pp5_reg;
    logic [95:0]        cube6_reg;
    logic [191:0]       r6_reg;
    pp_t                pp7_reg;
    pp_t                ppc2_reg;
    pp_t                ppc4_reg;
    logic [287:0]       r9_reg;
    logic [239:0]       qe_reg;
    logic [239:0]       qf_reg;
    pp_t                pp9_reg;
    logic [287:0]       r9b_reg;
    num_t               num_e_reg;
    num_t               num_f_reg;

    logic [NUM_W-1:0]   rem_e_reg [0:NDIV];
    logic [NUM_W-1:0]   rem_f_reg [0:NDIV];
    logic [287:0]       den_e_reg [0:NDIV];
    logic [319:0]       den_f_reg [0:NDIV];
    logic [NDIV-1:0]    quo_e_reg [0:NDIV];
    logic [NDIV-1:0]    quo_f_reg [0:NDIV];
    logic               neg_e_reg [0:NDIV];
    logic               neg_f_reg [0:NDIV];

    logic signed [47:0] pot_reg;
    logic signed [47:0] frc_reg;
    logic               ctc_reg;

    logic [31:0]        diff_next;
    logic [415:0]       prodl_next;
    logic [79:0]        shl_next;
    logic [60:0]        linmag_next;
    logic signed [61:0] lin_next;
    logic [415:0]       sq_full_next;
    logic [415:0]       cube_full_next;
    logic [415:0]       r6_full_next;
    logic [415:0]       r9_full_next;
    logic [415:0]       qe_full_next;
    logic [415:0]       qf_full_next;
    logic [415:0]       r10_full_next;
    logic [60:0]        mag_e_next;
    logic [60:0]        mag_f_next;
    logic signed [61:0] te_next;
    logic signed [61:0] tf_next;
    logic signed [63:0] pot_next;
    logic signed [63:0] frc_next;
    logic signed [47:0] pot_sat_next;
    logic signed [47:0] frc_sat_next;

    assign adv      = !vld_reg[LAT] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT];
    assign m_tdata  = {frc_reg, pot_reg};
    assign m_tuser  = ctc_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cutoff_reg  <= 32'd671088640;
            rep_e_reg   <= '0;
            att_e_reg   <= '0;
            rep_f_reg   <= '0;
            att_f_reg   <= '0;
            e_shift_reg <= '0;
            f_shift_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_CUTOFF:  cutoff_reg  <= cfg_data[31:0];
                REG_REP_E:   rep_e_reg   <= cfg_data;
                REG_ATT_E:   att_e_reg   <= cfg_data;
                REG_REP_F:   rep_f_reg   <= cfg_data;
                REG_ATT_F:   att_f_reg   <= cfg_data;
                REG_E_SHIFT: e_shift_reg <= cfg_data;
                REG_F_SHIFT: f_shift_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-1:1], s_tvalid};
        end
    end

    always_comb begin
        diff_next      = (s_tdata >= cutoff_reg) ? (s_tdata - cutoff_reg)
                                                 : (cutoff_reg - s_tdata);
        prodl_next     = mul_sum(ppl_reg);
        shl_next       = prodl_next[79:0] >> DIST_FRAC_BITS;
        linmag_next    = (shl_next > (80'd1 << CAP_BITS)) ? (61'd1 << CAP_BITS)
                                                          : shl_next[60:0];
        lin_next       = lneg_reg ? -$signed({1'b0, linmag_next})
                                  : $signed({1'b0, linmag_next});
        sq_full_next   = mul_sum(pp1_reg);
        cube_full_next = mul_sum(pp3_reg);
        r6_full_next   = mul_sum(pp5_reg);
        r9_full_next   = mul_sum(pp7_reg);
        qe_full_next   = mul_sum(ppc2_reg);
        qf_full_next   = mul_sum(ppc4_reg);
        r10_full_next  = mul_sum(pp9_reg);
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            sd_reg[1].ctc   <= s_tdata < cutoff_reg;
            sd_reg[1].rz    <= s_tdata == '0;
            sd_reg[1].rdist <= s_tdata;
            sd_reg[1].lin   <= '0;
            lneg_reg        <= f_shift_reg[47] != (s_tdata < cutoff_reg);
            pp1_reg         <= mul_pp(320'(s_tdata), 96'(s_tdata));
            ppl_reg         <= mul_pp(320'(mag48(f_shift_reg)), 96'(diff_next));

            sd_reg[2].ctc   <= sd_reg[1].ctc;
            sd_reg[2].rz    <= sd_reg[1].rz;
            sd_reg[2].rdist <= sd_reg[1].rdist;
            sd_reg[2].lin   <= lin_next;
            sq_reg          <= sq_full_next[63:0];

            pp3_reg        <= mul_pp(320'(sq_reg), 96'(sd_reg[2].rdist));
            cube_reg       <= cube_full_next[95:0];
            pp5_reg        <= mul_pp(320'(cube_reg), cube_reg);
            cube5_reg      <= cube_reg;
            r6_reg         <= r6_full_next[191:0];
            cube6_reg      <= cube5_reg;

            pp7_reg        <= mul_pp(320'(r6_reg), cube6_reg);
            ppc2_reg       <= mul_pp(320'(r6_reg), 96'(mag48(att_e_reg)));
            ppc4_reg       <= mul_pp(320'(r6_reg), 96'(mag48(att_f_reg)));

            r9_reg         <= r9_full_next[287:0];
            qe_reg         <= qe_full_next[239:0];
            qf_reg         <= qf_full_next[239:0];

            pp9_reg        <= mul_pp(320'(r9_reg), 96'(sd_reg[8].rdist));
            r9b_reg        <= r9_reg;
            num_e_reg      <= comb_num(NUM_W'(mag48(rep_e_reg)) << SH_PE,
                                       NUM_W'(qe_reg) << SH_QE,
                                       rep_e_reg[47],
                                       (att_e_reg != '0) && !att_e_reg[47]);
            num_f_reg      <= comb_num(NUM_W'(mag48(rep_f_reg)) << SH_PF,
                                       NUM_W'(qf_reg) << SH_QF,
                                       rep_f_reg[47],
                                       (att_f_reg != '0) && !att_f_reg[47]);

            rem_e_reg[0]   <= num_e_reg.mag;
            rem_f_reg[0]   <= num_f_reg.mag;
            neg_e_reg[0]   <= num_e_reg.neg;
            neg_f_reg[0]   <= num_f_reg.neg;
            den_e_reg[0]   <= r9b_reg;
            den_f_reg[0]   <= r10_full_next[319:0];
            quo_e_reg[0]   <= '0;
            quo_f_reg[0]   <= '0;
        end
    end

    for (genvar s = 3; s < LAT; s++) begin : g_side
        always_ff @(posedge clk) begin
            if (adv) begin
                sd_reg[s] <= sd_reg[s-1];
            end
        end
    end

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int K = NDIV - 1 - j;
        logic [NUM_W-1:0] dsh_e;
        logic [NUM_W-1:0] dsh_f;
        logic             ge_e;
        logic             ge_f;

        assign dsh_e = NUM_W'(den_e_reg[j]) << K;
        assign dsh_f = NUM_W'(den_f_reg[j]) << K;
        assign ge_e  = rem_e_reg[j] >= dsh_e;
        assign ge_f  = rem_f_reg[j] >= dsh_f;

        always_ff @(posedge clk) begin
            if (adv) begin
                rem_e_reg[j+1] <= ge_e ? (rem_e_reg[j] - dsh_e) : rem_e_reg[j];
                rem_f_reg[j+1] <= ge_f ? (rem_f_reg[j] - dsh_f) : rem_f_reg[j];
                quo_e_reg[j+1] <= quo_e_reg[j] | (NDIV'(ge_e) << K);
                quo_f_reg[j+1] <= quo_f_reg[j] | (NDIV'(ge_f) << K);
                den_e_reg[j+1] <= den_e_reg[j];
                den_f_reg[j+1] <= den_f_reg[j];
                neg_e_reg[j+1] <= neg_e_reg[j];
                neg_f_reg[j+1] <= neg_f_reg[j];
            end
        end
    end

    always_comb begin
        mag_e_next = quo_e_reg[NDIV][NDIV-1] ? (61'd1 << CAP_BITS)
                                             : {1'b0, quo_e_reg[NDIV][NDIV-2:0]};
        mag_f_next = quo_f_reg[NDIV][NDIV-1] ? (61'd1 << CAP_BITS)
                                             : {1'b0, quo_f_reg[NDIV][NDIV-2:0]};
        if (sd_reg[LAT-1].rz) begin
            te_next = zero_term(rep_e_reg, att_e_reg);
            tf_next = zero_term(rep_f_reg, att_f_reg);
        end else begin
            te_next = neg_e_reg[NDIV] ? -$signed({1'b0, mag_e_next})
                                      : $signed({1'b0, mag_e_next});
            tf_next = neg_f_reg[NDIV] ? -$signed({1'b0, mag_f_next})
                                      : $signed({1'b0, mag_f_next});
        end
        pot_next = 64'(te_next) - 64'(e_shift_reg) + 64'(sd_reg[LAT-1].lin);
        frc_next = 64'(tf_next) - 64'(f_shift_reg);
        if (pot_next > 64'sh7FFF_FFFF_FFFF) begin
            pot_sat_next = 48'sh7FFF_FFFF_FFFF;
        end else if (pot_next < -64'sh8000_0000_0000) begin
            pot_sat_next = 48'sh8000_0000_0000;
        end else begin
            pot_sat_next = pot_next[47:0];
        end
        if (frc_next > 64'sh7FFF_FFFF_FFFF) begin
            frc_sat_next = 48'sh7FFF_FFFF_FFFF;
        end else if (frc_next < -64'sh8000_0000_0000) begin
            frc_sat_next = 48'sh8000_0000_0000;
        end else begin
            frc_sat_next = frc_next[47:0];
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            ctc_reg <= sd_reg[LAT-1].ctc;
            pot_reg <= sd_reg[LAT-1].ctc ? pot_sat_next : '0;
            frc_reg <= sd_reg[LAT-1].ctc ? frc_sat_next : '0;
        end
    end

`ifndef SYNTHESIS
    a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("result without contact is not zero");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule
